// File: src/rrnh_pkg.sv
`default_nettype none
package rrnh_pkg;

  localparam int CoordW = 32;
  localparam int FracB  = 16;
  localparam int TolW   = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int QuotW  = ProdW + 2;
  localparam int NEdge  = 4;
  localparam int CfgAw  = 2;
  localparam logic [CfgAw-1:0] RegNearTol = 2'd0;
  localparam logic [TolW-1:0]  TolReset   = 16'd1638;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t direction_x;
    coord_t direction_y;
    coord_t rect_left;
    coord_t rect_bottom;
    coord_t rect_right;
    coord_t rect_top;
  } ray_in_t;

  typedef struct packed {
    logic              hit;
    coord_t            hit_distance;
    coord_t            hit_x;
    coord_t            hit_y;
    logic signed [1:0] normal_x;
    logic signed [1:0] normal_y;
  } ray_out_t;

  // saturate a wide signed value to coordinate range
  function automatic coord_t sat_coord(input logic signed [QuotW-1:0] v);
    logic signed [QuotW-1:0] mx;
    logic signed [QuotW-1:0] mn;
    begin
      mx = QuotW'(signed'({1'b0, {(CoordW-1){1'b1}}}));
      mn = -mx - QuotW'(1);
      if (v > mx) sat_coord = mx[CoordW-1:0];
      else if (v < mn) sat_coord = mn[CoordW-1:0];
      else sat_coord = v[CoordW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: src/rrnh_if.sv
`default_nettype none
interface rrnh_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/rrnh_div.sv
`default_nettype none
// Pipelined signed divide with round half away from zero.
// One quotient bit per stage; enable freezes every stage together.
module rrnh_div import rrnh_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [ProdW-1:0] num,
  input  wire logic signed [DiffW-1:0] den,
  output logic signed [QuotW-1:0]      quo
);
  localparam int NB = ProdW;
  localparam int DW = DiffW;

  logic [NB-1:0] n_r   [0:NB];
  logic [NB-1:0] q_r   [0:NB];
  logic [DW:0]   rem_r [0:NB];
  logic [DW-1:0] d_r   [0:NB];
  logic          neg_r [0:NB];
  logic [NB-1:0] na;
  logic [DW-1:0] da;

  always_comb begin
    na = num[NB-1] ? NB'(-num) : NB'(num);
    da = den[DW-1] ? DW'(-den) : DW'(den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= na;
      q_r[0]   <= '0;
      rem_r[0] <= '0;
      d_r[0]   <= da;
      neg_r[0] <= num[NB-1] ^ den[DW-1];
    end
  end

  // restoring division, MSB first
  for (genvar s = 0; s < NB; s++) begin : g_st
    logic [DW+1:0] sh;
    logic          ge;
    always_comb begin
      sh = {rem_r[s], n_r[s][NB-1-s]};
      ge = sh >= {2'b00, d_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s+1]   <= n_r[s];
        d_r[s+1]   <= d_r[s];
        neg_r[s+1] <= neg_r[s];
        q_r[s+1]   <= q_r[s] | (NB'(ge) << (NB-1-s));
        rem_r[s+1] <= ge ? (DW+1)'(sh - {2'b00, d_r[s]}) : sh[DW:0];
      end
    end
  end

  logic [QuotW-1:0] qm;
  always_comb begin
    qm = QuotW'(q_r[NB]);
    if ({rem_r[NB], 1'b0} >= {2'b00, d_r[NB]}) qm = qm + QuotW'(1);
  end
  always_ff @(posedge clk) if (en) quo <= neg_r[NB] ? -signed'(qm) : signed'(qm);
endmodule
`default_nettype wire

// File: src/ray_rect_nearest_hit_top.sv
`default_nettype none
// Ray versus axis-aligned rectangle, nearest edge hit, Q16.16.
// Fully pipelined: one ray per cycle unless the result side stalls. An
// input beat passes four compute stages, 68 stages in each of the
// bit-per-stage dividers for t and the hit point, and the result register.
// A stall on the result side freezes the whole pipeline, so input ready
// follows output ready whenever the result register holds a beat.
module ray_rect_nearest_hit_top import rrnh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rrnh_if.sink      in_ch,
  rrnh_if.source    out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CfgAw-1:0]  cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);
  localparam int Lat = ProdW + 2 + 4;

  logic [TolW-1:0] tol_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TolReset;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == RegNearTol)
      tol_r <= cfg_pwdata[TolW-1:0];
  end
  assign cfg_prdata = (cfg_paddr == RegNearTol) ? 32'(tol_r) : '0;

  // pipeline enable: advance unless the output holds a beat not taken
  logic en;
  logic [Lat-1:0] v_r;
  logic ovalid_r;
  ray_out_t odata_r;
  assign en = !ovalid_r || out_ch.ready;
  assign in_ch.ready = en;

  ray_in_t in;
  assign in = ray_in_t'(in_ch.data);

  // stage 1: per-edge differences, squares and the near-origin flag
  diff_t dd_r [NEdge], lo_r [NEdge], hi_r [NEdge], ob_r [NEdge], c_r [NEdge];
  diff_t da_r [NEdge], db_r [NEdge];
  logic signed [1:0] n_r [NEdge];
  logic [31:0] dsqd_r [NEdge];
  logic [63:0] asq_r [NEdge];
  logic near_r [NEdge];
  logic [63:0] dsq_r;
  logic [31:0] tsq_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NEdge; k++) begin
        logic ax;
        diff_t c, p0, p1, oa, ob, da, db;
        diff_t dd, tl;
        logic signed [16:0] ds;
        ax = k[0];
        c  = diff_t'(k == 0 ? in.rect_left : k == 1 ? in.rect_top :
             k == 2 ? in.rect_right : in.rect_bottom);
        p0 = diff_t'(k == 0 ? in.rect_bottom : k == 1 ? in.rect_left :
             k == 2 ? in.rect_top : in.rect_right);
        p1 = diff_t'(k == 0 ? in.rect_top : k == 1 ? in.rect_right :
             k == 2 ? in.rect_bottom : in.rect_left);
        oa = diff_t'(ax ? in.origin_y : in.origin_x);
        ob = diff_t'(ax ? in.origin_x : in.origin_y);
        da = diff_t'(ax ? in.direction_y : in.direction_x);
        db = diff_t'(ax ? in.direction_x : in.direction_y);
        dd = c - oa;
        tl = diff_t'($signed({1'b0, tol_r}));
        ds = $signed(dd[16:0]);
        dd_r[k] <= dd;
        c_r[k]  <= c;
        lo_r[k] <= (p0 < p1) ? p0 : p1;
        hi_r[k] <= (p0 < p1) ? p1 : p0;
        ob_r[k] <= ob;
        da_r[k] <= da;
        db_r[k] <= db;
        // edge distance within tolerance; its square only matters then
        near_r[k] <= (dd <= tl) && (dd >= -tl);
        dsqd_r[k] <= 32'(ds * ds);
        asq_r[k]  <= 64'(da * da);
        if (p0 == p1) n_r[k] <= 2'sd0;
        else if (ax ? (p1 > p0) : (p0 > p1)) n_r[k] <= 2'sd1;
        else n_r[k] <= -2'sd1;
      end
      dsq_r <= 64'(in.direction_x * in.direction_x) +
               64'(in.direction_y * in.direction_y);
      tsq_r <= 32'(tol_r * tol_r);
    end
  end

  // stage 2: products for range test and tolerance partial products
  logic signed [2*ProdW-1:0] base_r [NEdge], vl_r [NEdge], vh_r [NEdge];
  logic [63:0] pl_r [NEdge], ph_r [NEdge], ql_r [NEdge], qh_r [NEdge];
  logic ok2_r [NEdge], tchk_r [NEdge], near2_r [NEdge];
  diff_t dd2_r [NEdge], da2_r [NEdge], db2_r [NEdge], c2_r [NEdge], ob2_r [NEdge];
  diff_t lo2_r [NEdge], hi2_r [NEdge];
  logic signed [1:0] n2_r [NEdge];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NEdge; k++) begin
        logic s;
        s = (da_r[k] < 0) ? (n_r[k] == 2'sd1) : (da_r[k] > 0) ? (n_r[k] == -2'sd1) : 1'b0;
        ok2_r[k]  <= s;
        tchk_r[k] <= (dd_r[k] != 0) && ((dd_r[k] < 0) != (da_r[k] < 0));
        near2_r[k] <= near_r[k];
        base_r[k] <= (2*ProdW)'(dd_r[k] * db_r[k]);
        vl_r[k]   <= (2*ProdW)'((ob_r[k] - lo_r[k]) * da_r[k]);
        vh_r[k]   <= (2*ProdW)'((ob_r[k] - hi_r[k]) * da_r[k]);
        pl_r[k]   <= 64'(dsqd_r[k]) * 64'(dsq_r[31:0]);
        ph_r[k]   <= 64'(dsqd_r[k]) * 64'(dsq_r[63:32]);
        ql_r[k]   <= 64'(tsq_r) * 64'(asq_r[k][31:0]);
        qh_r[k]   <= 64'(tsq_r) * 64'(asq_r[k][63:32]);
        dd2_r[k] <= dd_r[k]; da2_r[k] <= da_r[k]; db2_r[k] <= db_r[k];
        c2_r[k] <= c_r[k]; ob2_r[k] <= ob_r[k]; lo2_r[k] <= lo_r[k];
        hi2_r[k] <= hi_r[k]; n2_r[k] <= n_r[k];
      end
    end
  end

  // stage 3: final validity per edge (96-bit tolerance compare)
  logic ok3_r [NEdge];
  diff_t dd3_r [NEdge], da3_r [NEdge], db3_r [NEdge], c3_r [NEdge], ob3_r [NEdge];
  diff_t lo3_r [NEdge], hi3_r [NEdge];
  logic signed [1:0] n3_r [NEdge];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NEdge; k++) begin
        logic [95:0] lhs, rhs;
        logic signed [2*ProdW:0] a, b;
        logic rin;
        lhs = 96'(pl_r[k]) + {ph_r[k], 32'd0};
        rhs = 96'(ql_r[k]) + {qh_r[k], 32'd0};
        a = (2*ProdW+1)'(vl_r[k]) + (2*ProdW+1)'(base_r[k]);
        b = (2*ProdW+1)'(vh_r[k]) + (2*ProdW+1)'(base_r[k]);
        rin = (da2_r[k] < 0) ? (a <= 0 && b >= 0) : (a >= 0 && b <= 0);
        // behind the origin: drop when farther than the tolerance allows
        ok3_r[k] <= ok2_r[k] && !(tchk_r[k] && (!near2_r[k] || lhs > rhs)) && rin;
        dd3_r[k] <= dd2_r[k]; da3_r[k] <= da2_r[k]; db3_r[k] <= db2_r[k];
        c3_r[k] <= c2_r[k]; ob3_r[k] <= ob2_r[k]; lo3_r[k] <= lo2_r[k];
        hi3_r[k] <= hi2_r[k]; n3_r[k] <= n2_r[k];
      end
    end
  end

  // stage 4: pick nearest edge, earlier edge on a tie (pairwise cross-multiplied compares)
  logic hit4_r, ax4_r;
  diff_t dd4_r, da4_r, db4_r, c4_r, ob4_r, lo4_r, hi4_r;
  logic signed [1:0] n4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [NEdge-1:0] nearer [NEdge];
      logic [NEdge-1:0] win;
      prod_t x, y;
      logic h, ax;
      diff_t bd, ba, bb, bc, bo, bl, bh;
      logic signed [1:0] bn;
      // nearer[k][j]: edge k lies strictly nearer along the ray than edge j
      for (int k = 0; k < NEdge; k++) begin
        nearer[k] = '0;
        for (int j = 0; j < k; j++) begin
          x = ProdW'(dd3_r[k] * da3_r[j]);
          y = ProdW'(dd3_r[j] * da3_r[k]);
          nearer[k][j] = ((da3_r[k] < 0) == (da3_r[j] < 0)) ? (x < y) : (y < x);
        end
      end
      // keep a valid edge that no earlier edge ties or beats and no later edge beats
      for (int k = 0; k < NEdge; k++) begin
        win[k] = ok3_r[k];
        for (int j = 0; j < NEdge; j++) begin
          if (j < k && ok3_r[j] && !nearer[k][j]) win[k] = 1'b0;
          if (j > k && ok3_r[j] && nearer[j][k]) win[k] = 1'b0;
        end
      end
      h = |win; ax = 1'b0; bd = '0; ba = '0; bb = '0; bc = '0; bo = '0; bl = '0;
      bh = '0; bn = '0;
      for (int k = 0; k < NEdge; k++) begin
        if (win[k]) begin
          ax = k[0]; bd = dd3_r[k]; ba = da3_r[k]; bb = db3_r[k];
          bc = c3_r[k]; bo = ob3_r[k]; bl = lo3_r[k]; bh = hi3_r[k]; bn = n3_r[k];
        end
      end
      hit4_r <= h; ax4_r <= ax; dd4_r <= bd; da4_r <= ba; db4_r <= bb;
      c4_r <= bc; ob4_r <= bo; lo4_r <= bl; hi4_r <= bh; n4_r <= bn;
    end
  end

  // dividers for t and the off-axis offset
  logic signed [QuotW-1:0] tq, oq;
  rrnh_div u_div_t (.clk, .en, .num(ProdW'(dd4_r) <<< FracB), .den(da4_r), .quo(tq));
  rrnh_div u_div_o (.clk, .en, .num(ProdW'(dd4_r * db4_r)), .den(da4_r), .quo(oq));

  // side delay line matching the divider latency
  localparam int DL = ProdW + 2;
  logic hd_r [0:DL-1], axd_r [0:DL-1];
  diff_t cd_r [0:DL-1], od_r [0:DL-1], ld_r [0:DL-1], hid_r [0:DL-1];
  logic signed [1:0] nd_r [0:DL-1];
  always_ff @(posedge clk) begin
    if (en) begin
      hd_r[0] <= hit4_r; axd_r[0] <= ax4_r; cd_r[0] <= c4_r; od_r[0] <= ob4_r;
      ld_r[0] <= lo4_r; hid_r[0] <= hi4_r; nd_r[0] <= n4_r;
      for (int i = 1; i < DL; i++) begin
        hd_r[i] <= hd_r[i-1]; axd_r[i] <= axd_r[i-1]; cd_r[i] <= cd_r[i-1];
        od_r[i] <= od_r[i-1]; ld_r[i] <= ld_r[i-1]; hid_r[i] <= hid_r[i-1];
        nd_r[i] <= nd_r[i-1];
      end
    end
  end

  // final: assemble result
  ray_out_t res;
  always_comb begin
    logic signed [QuotW-1:0] hb;
    coord_t hbc;
    hb = QuotW'(od_r[DL-1]) + QuotW'(sat_coord(oq));
    if (hb < QuotW'(ld_r[DL-1])) hb = QuotW'(ld_r[DL-1]);
    if (hb > QuotW'(hid_r[DL-1])) hb = QuotW'(hid_r[DL-1]);
    hbc = hb[CoordW-1:0];
    res = '0;
    res.hit_distance = {1'b0, {(CoordW-1){1'b1}}};
    if (hd_r[DL-1]) begin
      res.hit = 1'b1;
      res.hit_distance = sat_coord(tq);
      res.hit_x = axd_r[DL-1] ? hbc : cd_r[DL-1][CoordW-1:0];
      res.hit_y = axd_r[DL-1] ? cd_r[DL-1][CoordW-1:0] : hbc;
      res.normal_x = axd_r[DL-1] ? 2'sd0 : nd_r[DL-1];
      res.normal_y = axd_r[DL-1] ? nd_r[DL-1] : 2'sd0;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      ovalid_r <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[Lat-2:0], in_ch.valid};
      ovalid_r <= v_r[Lat-1];
    end
  end
  always_ff @(posedge clk) if (en) odata_r <= res;

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ch.ready |=> ovalid_r && $stable(odata_r))
    else $error("result dropped under stall");
  a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !odata_r.hit |-> odata_r.normal_x == 0 && odata_r.normal_y == 0)
    else $error("normal set without hit");
  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && odata_r.hit |-> (odata_r.normal_x == 0) != (odata_r.normal_y == 0))
    else $error("bad normal");
endmodule
`default_nettype wire
